// ----- hdl/mcpf_pkg.sv -----
// Shared types, constants and helper functions for the motor command packet framer.
// Used by mcpf_ctrl, mcpf_datapath and motor_command_packet_framer_unit.
package mcpf_pkg;

    // request kinds
    localparam logic [1:0] FUNC_POS   = 2'd0;
    localparam logic [1:0] FUNC_SPEED = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_GET   = 2'd3;

    // command bytes
    localparam logic [7:0] CMD_MOVE  = 8'd36;
    localparam logic [7:0] CMD_GET   = 8'd35;
    localparam logic [7:0] CMD_START = 8'd32;

    // CRC-14, reflected, over 7-bit bytes
    localparam logic [13:0] CRC_INIT = 14'h3fff;
    localparam logic [13:0] CRC_POLY = 14'h22f0;

    // byte source select codes
    localparam logic [3:0] SEL_ADDR  = 4'd0;
    localparam logic [3:0] SEL_CMD   = 4'd1;
    localparam logic [3:0] SEL_LEN   = 4'd2;
    localparam logic [3:0] SEL_CHAN  = 4'd3;
    localparam logic [3:0] SEL_ZERO  = 4'd4;
    localparam logic [3:0] SEL_ONE   = 4'd5;
    localparam logic [3:0] SEL_TWO   = 4'd6;
    localparam logic [3:0] SEL_NUM1  = 4'd7;
    localparam logic [3:0] SEL_NUM2  = 4'd8;
    localparam logic [3:0] SEL_PARAM = 4'd9;
    localparam logic [3:0] SEL_CRCL  = 4'd10;
    localparam logic [3:0] SEL_CRCH  = 4'd11;

    typedef struct packed {
        logic       capture;
        logic       emit;
        logic       crc_en;
        logic       last;
        logic [3:0] sel;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       send_limit;
        logic [2:0] n1;
        logic [2:0] n2;
        logic       space;
    } status_t;

    function automatic logic [13:0] crc7_update(input logic [13:0] crc_in,
                                                input logic [6:0]  data);
        logic [13:0] c;
        c = crc_in ^ {7'd0, data};
        for (int b = 0; b < 7; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/motor_command_packet_framer_unit.sv -----
// Motor command packet framer: one request in, 7 to 19 packet bytes out.
// Throughput: one byte per cycle from the sequencer while out_ready keeps the
// output register free; a new request is accepted only in the idle state,
// after the last byte of the current packet has been emitted.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
module motor_command_packet_framer_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [7:0]         device_address,
    input  logic [7:0]         channel_id,
    input  logic signed [29:0] target_value,
    input  logic signed [29:0] speed_limit,
    input  logic [7:0]         parameter_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         packet_byte,
    output logic               last_byte
);

    mcpf_pkg::cmd_t    cmd;
    mcpf_pkg::status_t status;

    mcpf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mcpf_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .func           (func),
        .device_address (device_address),
        .channel_id     (channel_id),
        .target_value   (target_value),
        .speed_limit    (speed_limit),
        .parameter_code (parameter_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .packet_byte    (packet_byte),
        .last_byte      (last_byte)
    );

endmodule

// ----- hdl/mcpf_ctrl.sv -----
// Sequencer for the packet framer: walks the packet fields one byte at a time.
// Uses mcpf_pkg for the command and status structs and select codes.
module mcpf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mcpf_pkg::status_t status,
    output mcpf_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ADDR  = 4'd1;
    localparam logic [3:0] ST_CMD   = 4'd2;
    localparam logic [3:0] ST_LEN   = 4'd3;
    localparam logic [3:0] ST_CHAN  = 4'd4;
    localparam logic [3:0] ST_ZERO  = 4'd5;
    localparam logic [3:0] ST_TAG1  = 4'd6;
    localparam logic [3:0] ST_NUM1  = 4'd7;
    localparam logic [3:0] ST_TAG2  = 4'd8;
    localparam logic [3:0] ST_NUM2  = 4'd9;
    localparam logic [3:0] ST_PARAM = 4'd10;
    localparam logic [3:0] ST_CRCL  = 4'd11;
    localparam logic [3:0] ST_CRCH  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       emit;

    assign in_ready = (state_reg == ST_IDLE);
    assign emit     = (state_reg != ST_IDLE) && status.space;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd.capture = (state_reg == ST_IDLE) && in_valid;
        cmd.emit    = emit;
        cmd.crc_en  = 1'b1;
        cmd.last    = 1'b0;
        cmd.sel     = mcpf_pkg::SEL_ADDR;
        cmd.idx     = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.sel = mcpf_pkg::SEL_ADDR;
                if (emit)
                    state_next = ST_CMD;
            end
            ST_CMD:
            begin
                cmd.sel = mcpf_pkg::SEL_CMD;
                if (emit)
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.sel = mcpf_pkg::SEL_LEN;
                if (emit)
                    state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                cmd.sel = mcpf_pkg::SEL_CHAN;
                if (emit)
                    state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                cmd.sel = mcpf_pkg::SEL_ZERO;
                if (emit)
                begin
                    case (status.func)
                        mcpf_pkg::FUNC_POS:   state_next = ST_TAG1;
                        mcpf_pkg::FUNC_SPEED: state_next = ST_TAG1;
                        mcpf_pkg::FUNC_START: state_next = ST_CRCL;
                        default:              state_next = ST_PARAM;
                    endcase
                end
            end
            ST_TAG1:
            begin
                cmd.sel = (status.func == mcpf_pkg::FUNC_POS) ? mcpf_pkg::SEL_ONE
                                                             : mcpf_pkg::SEL_TWO;
                if (emit)
                begin
                    state_next = ST_NUM1;
                    idx_next   = 3'd0;
                end
            end
            ST_NUM1:
            begin
                cmd.sel = mcpf_pkg::SEL_NUM1;
                if (emit)
                begin
                    if (idx_reg == status.n1 - 3'd1)
                    begin
                        idx_next = 3'd0;
                        if ((status.func == mcpf_pkg::FUNC_POS) && status.send_limit)
                            state_next = ST_TAG2;
                        else
                            state_next = ST_CRCL;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            ST_TAG2:
            begin
                cmd.sel = mcpf_pkg::SEL_TWO;
                if (emit)
                begin
                    state_next = ST_NUM2;
                    idx_next   = 3'd0;
                end
            end
            ST_NUM2:
            begin
                cmd.sel = mcpf_pkg::SEL_NUM2;
                if (emit)
                begin
                    if (idx_reg == status.n2 - 3'd1)
                    begin
                        idx_next   = 3'd0;
                        state_next = ST_CRCL;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            ST_PARAM:
            begin
                cmd.sel = mcpf_pkg::SEL_PARAM;
                if (emit)
                    state_next = ST_CRCL;
            end
            ST_CRCL:
            begin
                cmd.sel    = mcpf_pkg::SEL_CRCL;
                cmd.crc_en = 1'b0;
                if (emit)
                    state_next = ST_CRCH;
            end
            ST_CRCH:
            begin
                cmd.sel    = mcpf_pkg::SEL_CRCH;
                cmd.crc_en = 1'b0;
                cmd.last   = 1'b1;
                if (emit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- hdl/mcpf_datapath.sv -----
// Datapath for the packet framer: request registers, number packing, byte mux,
// running CRC and the output register. Uses mcpf_pkg for structs and constants.
module mcpf_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  mcpf_pkg::cmd_t      cmd,
    output mcpf_pkg::status_t   status,
    input  logic [1:0]          func,
    input  logic [7:0]          device_address,
    input  logic [7:0]          channel_id,
    input  logic signed [29:0]  target_value,
    input  logic signed [29:0]  speed_limit,
    input  logic [7:0]          parameter_code,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          packet_byte,
    output logic                last_byte
);

    logic [1:0]  func_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  chan_reg;
    logic [7:0]  param_reg;
    logic        send_limit_reg;
    logic [30:0] v1_reg;
    logic [30:0] v2_reg;
    logic [13:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;

    logic [2:0]  n1, n2;
    logic [7:0]  dlen;
    logic [7:0]  byte_sel;
    logic [13:0] crc_out;

    // magnitude shifted left once, sign in bit 0
    function automatic logic [30:0] pack_word(input logic [29:0] r);
        logic [29:0] mag;
        mag = r[29] ? (~r + 30'd1) : r;
        return {mag, r[29]};
    endfunction

    function automatic logic [2:0] pack_count(input logic [30:0] v);
        logic [2:0] n;
        if (v[30:6] == 25'd0)
            n = 3'd1;
        else if (v[30:12] == 19'd0)
            n = 3'd2;
        else if (v[30:18] == 13'd0)
            n = 3'd3;
        else if (v[30:24] == 7'd0)
            n = 3'd4;
        else
            n = 3'd5;
        return n;
    endfunction

    // six bits per byte, bit 6 set while higher bits remain
    function automatic logic [7:0] pack_byte(input logic [30:0] v, input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = {1'b0, |v[30:6],  v[5:0]};
            3'd1:    b = {1'b0, |v[30:12], v[11:6]};
            3'd2:    b = {1'b0, |v[30:18], v[17:12]};
            3'd3:    b = {1'b0, |v[30:24], v[23:18]};
            default: b = {1'b0, v[30],     v[29:24]};
        endcase
        return b;
    endfunction

    assign n1 = pack_count(v1_reg);
    assign n2 = pack_count(v2_reg);

    always_comb
    begin
        case (func_reg)
            mcpf_pkg::FUNC_POS:
                dlen = send_limit_reg ? (8'd4 + {5'd0, n1} + {5'd0, n2})
                                      : (8'd3 + {5'd0, n1});
            mcpf_pkg::FUNC_SPEED: dlen = 8'd3 + {5'd0, n1};
            mcpf_pkg::FUNC_START: dlen = 8'd2;
            default:              dlen = 8'd3;
        endcase
    end

    assign crc_out = crc_reg ^ mcpf_pkg::CRC_INIT;

    always_comb
    begin
        case (cmd.sel)
            mcpf_pkg::SEL_ADDR:  byte_sel = addr_reg;
            mcpf_pkg::SEL_CMD:
            begin
                case (func_reg)
                    mcpf_pkg::FUNC_START: byte_sel = mcpf_pkg::CMD_START;
                    mcpf_pkg::FUNC_GET:   byte_sel = mcpf_pkg::CMD_GET;
                    default:              byte_sel = mcpf_pkg::CMD_MOVE;
                endcase
            end
            mcpf_pkg::SEL_LEN:   byte_sel = dlen;
            mcpf_pkg::SEL_CHAN:  byte_sel = chan_reg;
            mcpf_pkg::SEL_ZERO:  byte_sel = 8'd0;
            mcpf_pkg::SEL_ONE:   byte_sel = 8'd1;
            mcpf_pkg::SEL_TWO:   byte_sel = 8'd2;
            mcpf_pkg::SEL_NUM1:  byte_sel = pack_byte(v1_reg, cmd.idx);
            mcpf_pkg::SEL_NUM2:  byte_sel = pack_byte(v2_reg, cmd.idx);
            mcpf_pkg::SEL_PARAM: byte_sel = param_reg;
            mcpf_pkg::SEL_CRCL:  byte_sel = {1'b0, crc_out[6:0]};
            mcpf_pkg::SEL_CRCH:  byte_sel = {1'b0, crc_out[13:7]};
            default:             byte_sel = 8'd0;
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.capture)
            crc_next = mcpf_pkg::CRC_INIT;
        else if (cmd.emit && cmd.crc_en)
            crc_next = mcpf_pkg::crc7_update(crc_reg, byte_sel[6:0]);
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (cmd.capture)
        begin
            func_reg       <= func;
            addr_reg       <= device_address;
            chan_reg       <= channel_id;
            param_reg      <= parameter_code;
            send_limit_reg <= ~speed_limit[29];
            v1_reg         <= pack_word(target_value);
            v2_reg         <= pack_word(speed_limit);
        end
        if (cmd.emit)
        begin
            byte_reg <= byte_sel;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.func       = func_reg;
    assign status.send_limit = send_limit_reg;
    assign status.n1         = n1;
    assign status.n2         = n2;
    assign status.space      = ~out_valid_reg | out_ready;

    assign out_valid   = out_valid_reg;
    assign packet_byte = byte_reg;
    assign last_byte   = last_reg;

endmodule

// ----- tb/sv/motor_command_packet_framer_unit_tb.sv -----
// Self-checking testbench for motor_command_packet_framer_unit: directed and random requests,
// each packet predicted byte by byte (header, bit-packed numbers, CRC-14) and compared.
// Depends on mcpf_pkg for request kinds, command bytes and CRC constants.
`timescale 1ns / 100ps

module motor_command_packet_framer_unit_tb;

    localparam int PKT_MAX     = 19;
    localparam int ITEMS       = 400;
    localparam int LONG_HOLD   = 400;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    // receiver stall patterns
    localparam int RX_FULL   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_BEAT   = 3;

    localparam logic [29:0] N_ZERO    = 30'h0000_0000;
    localparam logic [29:0] N_ONE     = 30'h0000_0001;
    localparam logic [29:0] N_MINUS1  = 30'h3fff_ffff;
    localparam logic [29:0] N_MAX     = 30'h1fff_ffff;
    localparam logic [29:0] N_NEG_MAX = 30'h2000_0001;
    localparam logic [29:0] N_MIN     = 30'h2000_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [7:0]  chan;
        logic [29:0] target;
        logic [29:0] limit;
        logic [7:0]  param;
        logic [7:0]  hdr_cmd;   // typed-in command byte
        logic [7:0]  hdr_len;   // typed-in data length, 0 when not typed
    } request_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [7:0]         device_address;
    logic [7:0]         channel_id;
    logic signed [29:0] target_value;
    logic signed [29:0] speed_limit;
    logic [7:0]         parameter_code;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         packet_byte;
    logic               last_byte;

    out_byte_t   pending_bytes[$];
    logic [15:0] header_notes[$];
    logic [7:0]  frame_buf [0:PKT_MAX-1];
    int          frame_len;
    int          mismatch_count = 0;
    int          bytes_seen = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    int          hold_asked = 0;
    int          hold_given = 0;

    motor_command_packet_framer_unit u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .device_address (device_address),
        .channel_id     (channel_id),
        .target_value   (target_value),
        .speed_limit    (speed_limit),
        .parameter_code (parameter_code),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .packet_byte    (packet_byte),
        .last_byte      (last_byte)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("MISMATCH at %0t, byte %0d: %s got 0x%0h expected 0x%0h",
                 $time, bytes_seen, what, got, want);
        mismatch_count++;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        frame_buf[frame_len] = b;
        frame_len++;
    endfunction

    // sign in bit 0, six bits per byte, bit 6 marks more to follow, five bytes at most
    function automatic void append_number(input logic [29:0] raw);
        logic [31:0] mag;
        logic [31:0] bits;
        int n;
        mag  = raw[29] ? {2'b00, ~raw + 30'd1} : {2'b00, raw};
        bits = (mag << 1) | {31'd0, raw[29]};
        for (n = 0; n < 5; n++)
        begin
            append_byte({1'b0, bits >= 32'd64, bits[5:0]});
            bits = bits >> 6;
            if (bits == 32'd0)
                break;
        end
    endfunction

    function automatic void frame_request(input request_t r);
        logic [13:0] crc;
        int i;
        int b;
        frame_len = 0;
        append_byte(r.addr);
        append_byte(r.kind == mcpf_pkg::FUNC_START ? mcpf_pkg::CMD_START :
                    r.kind == mcpf_pkg::FUNC_GET   ? mcpf_pkg::CMD_GET   :
                                                     mcpf_pkg::CMD_MOVE);
        append_byte(8'd0);
        append_byte(r.chan);
        append_byte(8'd0);
        case (r.kind)
            mcpf_pkg::FUNC_POS:
            begin
                append_byte(8'd1);
                append_number(r.target);
                if (!r.limit[29])
                begin
                    append_byte(8'd2);
                    append_number(r.limit);
                end
            end
            mcpf_pkg::FUNC_SPEED:
            begin
                append_byte(8'd2);
                append_number(r.target);
            end
            mcpf_pkg::FUNC_GET:
                append_byte(r.param);
            default:
                ;
        endcase
        frame_buf[2] = 8'(frame_len - 3);
        crc = mcpf_pkg::CRC_INIT;
        for (i = 0; i < frame_len; i++)
        begin
            crc = crc ^ {7'd0, frame_buf[i][6:0]};
            for (b = 0; b < 7; b++)
                crc = crc[0] ? ((crc >> 1) ^ mcpf_pkg::CRC_POLY) : (crc >> 1);
        end
        crc = crc ^ mcpf_pkg::CRC_INIT;
        append_byte({1'b0, crc[6:0]});
        append_byte({1'b0, crc[13:7]});
    endfunction

    function automatic logic [29:0] random_number();
        logic [29:0] v;
        case ($urandom_range(0, 3))
            0: v = 30'($urandom_range(0, 128)) - 30'd64;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: v = N_MAX;
                    1: v = N_NEG_MAX;
                    2: v = N_MIN;
                    3: v = N_MINUS1;
                    4: v = 30'd64 << $urandom_range(0, 22);
                    default: v = -(30'd1 << $urandom_range(0, 28));
                endcase
            end
            default: v = 30'($urandom);
        endcase
        return v;
    endfunction

    // drop valid for a random gap at the end of each burst
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic offer_request(input request_t r);
        in_valid       <= 1'b1;
        func           <= r.kind;
        device_address <= r.addr;
        channel_id     <= r.chan;
        target_value   <= r.target;
        speed_limit    <= r.limit;
        parameter_code <= r.param;
        header_notes.push_back({r.hdr_cmd, r.hdr_len});
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    initial
    begin : sender
        request_t directed [0:23];
        request_t r;
        int i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = mcpf_pkg::FUNC_POS;
        device_address = 8'd0;
        channel_id     = 8'd0;
        target_value   = '0;
        speed_limit    = '0;
        parameter_code = 8'd0;

        // kind, address, channel, target, limit, parameter, command, data length
        directed[0]  = {mcpf_pkg::FUNC_START, 8'h00, 8'h00, N_ZERO, N_MINUS1, 8'h00,
                        mcpf_pkg::CMD_START, 8'd2};
        directed[1]  = {mcpf_pkg::FUNC_START, 8'hff, 8'hff, N_MAX, N_MAX, 8'hff,
                        mcpf_pkg::CMD_START, 8'd2};
        directed[2]  = {mcpf_pkg::FUNC_GET, 8'h80, 8'h31, N_ZERO, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_GET, 8'd3};
        directed[3]  = {mcpf_pkg::FUNC_GET, 8'hff, 8'h54, N_MIN, N_MIN, 8'hff,
                        mcpf_pkg::CMD_GET, 8'd3};
        directed[4]  = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h31, N_ZERO, N_MINUS1, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd4};
        directed[5]  = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h32, N_ONE, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd4};
        directed[6]  = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h44, N_MINUS1, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd4};
        directed[7]  = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h31, 30'd31, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd4};
        directed[8]  = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h31, 30'd32, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd5};
        directed[9]  = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h31, 30'h3fffffe0, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd5};
        directed[10] = {mcpf_pkg::FUNC_SPEED, 8'h00, 8'h31, N_MAX, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd8};
        directed[11] = {mcpf_pkg::FUNC_SPEED, 8'hff, 8'h31, N_NEG_MAX, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd8};
        directed[12] = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h31, N_MIN, N_MAX, 8'hff,
                        mcpf_pkg::CMD_MOVE, 8'd8};
        directed[13] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, N_ZERO, N_MINUS1, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd4};
        directed[14] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, N_ZERO, N_ZERO, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd6};
        directed[15] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, N_MAX, N_MAX, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd14};
        // a negative limit is left out of the packet
        directed[16] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, N_MIN, N_MIN, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd8};
        directed[17] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, N_NEG_MAX, N_MAX, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd14};
        directed[18] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h32, N_MINUS1, N_ONE, 8'h00,
                        mcpf_pkg::CMD_MOVE, 8'd6};
        directed[19] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, 30'd12345, 30'd4000, 8'h00,
                        8'h00, 8'h00};
        directed[20] = {mcpf_pkg::FUNC_POS, 8'h7f, 8'h44, 30'h2aaaaaaa, 30'h15555555, 8'ha5,
                        8'h00, 8'h00};
        directed[21] = {mcpf_pkg::FUNC_SPEED, 8'h80, 8'h54, 30'h15555555, N_MIN, 8'h5a,
                        8'h00, 8'h00};
        directed[22] = {mcpf_pkg::FUNC_GET, 8'h80, 8'h31, N_MAX, N_MIN, 8'h5a,
                        mcpf_pkg::CMD_GET, 8'd3};
        directed[23] = {mcpf_pkg::FUNC_POS, 8'h80, 8'h31, 30'h3ffff000, 30'h1000, 8'h00,
                        8'h00, 8'h00};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 24; i++)
        begin
            pace_sender();
            offer_request(directed[i]);
        end
        drain_outputs();

        for (i = 0; i < ITEMS; i++)
        begin
            if (i == 120)
                drain_outputs();
            // keep offering without gaps while the receiver holds off
            if (i == 200)
            begin
                hold_asked++;
                burst_left = 60;
            end
            pace_sender();
            r.kind    = 2'($urandom_range(0, 3));
            r.addr    = ($urandom_range(0, 2) == 0) ? 8'h80 : 8'($urandom);
            r.chan    = 8'($urandom);
            r.target  = random_number();
            case ($urandom_range(0, 3))
                0: r.limit = N_MINUS1;
                1: r.limit = random_number();
                default: r.limit = random_number() & N_MAX;
            endcase
            r.param   = 8'($urandom);
            r.hdr_cmd = 8'h00;
            r.hdr_len = 8'h00;
            offer_request(r);
        end
        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        out_ready = 1'b0;
        mode = RX_FULL;
        span = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_given)
            begin
                hold_given = hold_asked;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(RX_FULL, RX_BEAT);
                span = $urandom_range(16, 160);
            end
            span--;
            tick++;
            case (mode)
                RX_FULL:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 7) != 0);
                default:   out_ready <= ((tick % 5) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin : scoreboard
        request_t    seen;
        logic [15:0] note;
        out_byte_t   want;
        int          k;
        if (rst_n && in_valid && in_ready)
        begin
            seen = {func, device_address, channel_id, target_value, speed_limit,
                    parameter_code, 16'd0};
            frame_request(seen);
            note = header_notes.pop_front();
            if (note[7:0] != 8'd0)
            begin
                if (frame_buf[1] != note[15:8])
                    flag_mismatch("predicted command byte", 32'(frame_buf[1]),
                                  32'(note[15:8]));
                if (frame_buf[2] != note[7:0])
                    flag_mismatch("predicted data length", 32'(frame_buf[2]),
                                  32'(note[7:0]));
            end
            for (k = 0; k < frame_len; k++)
                pending_bytes.push_back({frame_buf[k], k == frame_len - 1});
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
                flag_mismatch("unexpected packet_byte", 32'(packet_byte), 0);
            else
            begin
                want = pending_bytes.pop_front();
                if (packet_byte !== want.data)
                    flag_mismatch("packet_byte", 32'(packet_byte), 32'(want.data));
                if (last_byte !== want.last)
                    flag_mismatch("last_byte", 32'(last_byte), 32'(want.last));
            end
            bytes_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
